[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/utt_pkg.sv]
package utt_pkg;

   localparam int ERROR_COUNT_BITS_DEF = 16;
   localparam int CP_BITS              = 21;
   localparam int TOTAL_BITS           = 16;

   // A completed character handed from the decoder to the mapper.
   typedef struct packed {
      logic                 bad_lead;
      logic [CP_BITS-1:0]   code;
   } char_item_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] cp_byte;
   } lookup_type;

   // Reverse table for code points 0x80..0xFFFF.
   function automatic lookup_type cp1252_lookup(input logic [15:0] cp);
      lookup_type r;
      r.hit     = 1'b1;
      r.cp_byte = cp[7:0];
      if (cp[15:8] == 8'h00 && cp[7] && (cp[6] || cp[5])) begin
         r.hit = 1'b1;
      end else begin
         case (cp)
            16'h0081, 16'h008D, 16'h008F, 16'h0090, 16'h009D: r.cp_byte = cp[7:0];
            16'h20AC: r.cp_byte = 8'h80;
            16'h201A: r.cp_byte = 8'h82;
            16'h0192: r.cp_byte = 8'h83;
            16'h201E: r.cp_byte = 8'h84;
            16'h2026: r.cp_byte = 8'h85;
            16'h2020: r.cp_byte = 8'h86;
            16'h2021: r.cp_byte = 8'h87;
            16'h02C6: r.cp_byte = 8'h88;
            16'h2030: r.cp_byte = 8'h89;
            16'h0160: r.cp_byte = 8'h8A;
            16'h2039: r.cp_byte = 8'h8B;
            16'h0152: r.cp_byte = 8'h8C;
            16'h017D: r.cp_byte = 8'h8E;
            16'h2018: r.cp_byte = 8'h91;
            16'h2019: r.cp_byte = 8'h92;
            16'h201C: r.cp_byte = 8'h93;
            16'h201D: r.cp_byte = 8'h94;
            16'h2022: r.cp_byte = 8'h95;
            16'h2013: r.cp_byte = 8'h96;
            16'h2014: r.cp_byte = 8'h97;
            16'h02DC: r.cp_byte = 8'h98;
            16'h2122: r.cp_byte = 8'h99;
            16'h0161: r.cp_byte = 8'h9A;
            16'h203A: r.cp_byte = 8'h9B;
            16'h0153: r.cp_byte = 8'h9C;
            16'h017E: r.cp_byte = 8'h9E;
            16'h0178: r.cp_byte = 8'h9F;
            default: begin
               r.hit     = 1'b0;
               r.cp_byte = 8'h00;
            end
         endcase
      end
      return r;
   endfunction

endpackage

[rtl/utt_decode.sv]
module utt_decode
   import utt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_in_byte,
   output logic          item_valid,
   input  logic          item_ready,
   output char_item_type item
);

   logic [1:0]         bytes_left_ff, bytes_left_in;
   logic [CP_BITS-1:0] code_accum_ff, code_accum_in;
   logic               item_valid_ff, item_valid_in;
   char_item_type      item_ff, item_in;
   logic               accept;
   logic               done;
   logic               bad_lead;

   assign req_ready = !item_valid_ff || item_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      bytes_left_in = bytes_left_ff;
      code_accum_in = code_accum_ff;
      done          = 1'b0;
      bad_lead      = 1'b0;
      if (bytes_left_ff != 2'd0) begin
         code_accum_in = {code_accum_ff[CP_BITS-7:0], req_in_byte[5:0]};
         bytes_left_in = bytes_left_ff - 2'd1;
         done          = (bytes_left_ff == 2'd1);
      end else if (!req_in_byte[7]) begin
         code_accum_in = {{(CP_BITS-8){1'b0}}, req_in_byte};
         done          = 1'b1;
      end else if (req_in_byte[7:5] == 3'b110) begin
         code_accum_in = {{(CP_BITS-5){1'b0}}, req_in_byte[4:0]};
         bytes_left_in = 2'd1;
      end else if (req_in_byte[7:4] == 4'b1110) begin
         code_accum_in = {{(CP_BITS-4){1'b0}}, req_in_byte[3:0]};
         bytes_left_in = 2'd2;
      end else if (req_in_byte[7:3] == 5'b11110) begin
         code_accum_in = {{(CP_BITS-3){1'b0}}, req_in_byte[2:0]};
         bytes_left_in = 2'd3;
      end else begin
         // invalid lead: consume and report as one bad character
         done     = 1'b1;
         bad_lead = 1'b1;
      end
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      if (item_ready) begin
         item_valid_in = 1'b0;
      end
      if (accept && done) begin
         item_valid_in     = 1'b1;
         item_in.bad_lead  = bad_lead;
         item_in.code      = code_accum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 2'd0;
         code_accum_ff <= '0;
         item_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            bytes_left_ff <= bytes_left_in;
            code_accum_ff <= code_accum_in;
         end
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

   `include "assert_macros.svh"

   `ASSERT_NEXT(a_ascii_completes, clock, reset,
      accept && bytes_left_ff == 2'd0 && !req_in_byte[7],
      item_valid_ff && !item_ff.bad_lead && bytes_left_ff == 2'd0)
   `ASSERT_NEXT(a_pending_no_item, clock, reset,
      accept && bytes_left_ff > 2'd1 && !item_ready,
      item_valid_ff == $past(item_valid_ff))
   `ASSERT_NEXT(a_cont_counts_down, clock, reset,
      accept && bytes_left_ff != 2'd0,
      bytes_left_ff == $past(bytes_left_ff) - 2'd1)

endmodule

[rtl/utt_map.sv]
module utt_map
   import utt_pkg::*;
#(
   parameter int ERROR_COUNT_BITS = ERROR_COUNT_BITS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  char_item_type         item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_bad_char,
   output logic [TOTAL_BITS-1:0] rsp_error_total
);

   logic [ERROR_COUNT_BITS-1:0] count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  out_byte_ff, out_byte_in;
   logic                        bad_ff, bad_in;
   logic [TOTAL_BITS-1:0]       total_ff, total_in;
   logic                        load;
   logic                        is_ascii;
   logic                        is_big;
   lookup_type                  hit;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign load       = item_valid && item_ready;

   assign is_ascii = (item.code[CP_BITS-1:7] == '0);
   assign is_big   = (item.code[CP_BITS-1:16] != '0);
   assign hit      = cp1252_lookup(item.code[15:0]);

   always_comb begin
      bad_in      = 1'b0;
      out_byte_in = 8'h00;
      if (item.bad_lead || is_big) begin
         bad_in = 1'b1;
      end else if (is_ascii) begin
         out_byte_in = item.code[7:0];
      end else if (hit.hit) begin
         out_byte_in = hit.cp_byte;
      end else begin
         bad_in = 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (bad_in && count_ff != '1) begin
         count_in = count_ff + 1'b1;
      end
   end

   // show the low bits of the count, widened if the counter is narrow
   if (ERROR_COUNT_BITS >= TOTAL_BITS) begin : g_total_wide
      assign total_in = count_in[TOTAL_BITS-1:0];
   end else begin : g_total_narrow
      assign total_in = {{(TOTAL_BITS-ERROR_COUNT_BITS){1'b0}}, count_in};
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= out_byte_in;
         bad_ff      <= bad_in;
         total_ff    <= total_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_bad_char    = bad_ff;
   assign rsp_error_total = total_ff;

   `include "assert_macros.svh"

   `ASSERT_IMPLY(a_bad_zero_byte, clock, reset,
      rsp_valid_ff && bad_ff, out_byte_ff == 8'h00)
   `ASSERT_NEXT(a_count_holds_idle, clock, reset,
      !load, count_ff == $past(count_ff))
   `ASSERT_NEXT(a_count_holds_good, clock, reset,
      load && !bad_in, count_ff == $past(count_ff))

endmodule

[rtl/utt_top.sv]
// UTF-8 to Windows-1252 transcoder.
// Request channel: req_valid/req_ready carry one raw UTF-8 byte on req_in_byte.
// Result channel: rsp_valid/rsp_ready carry one character: rsp_out_byte, the
// Windows-1252 byte (0 when rsp_bad_char is set), and rsp_error_total, the
// saturating count of bad characters including this one (low 16 bits).
// Lead bytes of multi-byte sequences and all but the last continuation byte
// give no result; the last byte of a character gives exactly one.
// On the edge that accepts the last byte, the decode register loads the character;
// the lookup result then loads the output register, which raises rsp_valid.
// Throughput: one byte per cycle; each stage holds one item and refills in
// the cycle it drains, so a byte is taken every cycle while results flow.
// When the receiver stalls, the result is held and one more completed
// character waits in the decode register; req_ready drops once both are full.
// Reset (synchronous, active high) clears the pending sequence, the error
// count and both valid flags; results in flight are dropped.
module utf8_to_cp1252_transcoder_unit
   import utt_pkg::*;
#(
   parameter int ERROR_COUNT_BITS = ERROR_COUNT_BITS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_in_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_bad_char,
   output logic [TOTAL_BITS-1:0] rsp_error_total
);

   logic          item_valid;
   logic          item_ready;
   char_item_type item;

   utt_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .item        (item)
   );

   utt_map #(
      .ERROR_COUNT_BITS (ERROR_COUNT_BITS)
   ) u_map (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item_ready      (item_ready),
      .item            (item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_bad_char    (rsp_bad_char),
      .rsp_error_total (rsp_error_total)
   );

endmodule
